// ----- sv/pscc_pkg.sv -----
package pscc_pkg;

    // Request kinds carried in s_tuser
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_PWM  = 2'd1;
    localparam logic [1:0] REQ_STEP = 2'd2;
    localparam logic [1:0] REQ_ACK  = 2'd3;

    // Command bytes
    localparam logic [7:0] CMD_START    = 8'hBE;
    localparam logic [7:0] CMD_PEN_UP   = 8'hC0;
    localparam logic [7:0] CMD_PEN_DOWN = 8'hC1;
    localparam logic [7:0] CMD_END      = 8'hDE;
    localparam logic [7:0] CMD_BACK     = 8'h01;
    localparam logic [7:0] CMD_HOLD     = 8'h11;
    localparam logic [7:0] CMD_FWD      = 8'h10;

    // Controller phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_RECV   = 2'd1;
    localparam logic [1:0] PH_MOVING = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // Direction codes, two's complement
    localparam logic signed [1:0] DIR_BACK = -2'sd1;
    localparam logic signed [1:0] DIR_HOLD = 2'sd0;
    localparam logic signed [1:0] DIR_FWD  = 2'sd1;

    // Register indexes on the APB port
    localparam logic [1:0] REG_PEN_UP   = 2'd0;
    localparam logic [1:0] REG_PEN_DOWN = 2'd1;
    localparam logic [1:0] REG_PERIOD   = 2'd2;

    // Register reset values
    localparam logic [7:0] PEN_UP_RESET   = 8'd11;
    localparam logic [7:0] PEN_DOWN_RESET = 8'd9;
    localparam logic [7:0] PERIOD_RESET   = 8'd160;

    localparam int unsigned ADDR_W = 4;

    typedef struct packed {
        logic [7:0] pen_up_width;
        logic [7:0] pen_down_width;
        logic [7:0] pwm_period;
    } cfg_t;

    typedef struct packed {
        logic              step_valid;
        logic signed [1:0] step_a;
        logic signed [1:0] step_b;
        logic              pwm_level;
        logic [1:0]        ctrl_phase;
    } res_t;

endpackage

// ----- sv/pscc_cfg.sv -----
module pscc_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pscc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output pscc_pkg::cfg_t                cfg
);
    import pscc_pkg::*;

    logic [7:0] pen_up_reg;
    logic [7:0] pen_down_reg;
    logic [7:0] period_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    // Write the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_up_reg   <= PEN_UP_RESET;
            pen_down_reg <= PEN_DOWN_RESET;
            period_reg   <= PERIOD_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PEN_UP:   pen_up_reg   <= pwdata[7:0];
                REG_PEN_DOWN: pen_down_reg <= pwdata[7:0];
                REG_PERIOD:   period_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Decode reads
    always_comb begin
        prdata = 32'd0;
        unique case (reg_idx)
            REG_PEN_UP:   prdata = {24'd0, pen_up_reg};
            REG_PEN_DOWN: prdata = {24'd0, pen_down_reg};
            REG_PERIOD:   prdata = {24'd0, period_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.pen_up_width   = pen_up_reg;
    assign cfg.pen_down_width = pen_down_reg;
    assign cfg.pwm_period     = period_reg;

endmodule

// ----- sv/pscc_core.sv -----
module pscc_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  logic [1:0]      req_type,
    input  logic [7:0]      rx_byte,
    input  pscc_pkg::cfg_t  cfg,
    output pscc_pkg::res_t  res
);
    import pscc_pkg::*;

    logic [1:0]        phase_reg,   phase_next;
    logic              tgt_b_reg,   tgt_b_next;
    logic signed [1:0] dir_a_reg,   dir_a_next;
    logic signed [1:0] dir_b_reg,   dir_b_next;
    logic [7:0]        width_reg,   width_next;
    logic [7:0]        count_reg,   count_next;
    logic              pwm_reg,     pwm_next;
    logic [7:0]        count_inc;
    logic              step_fire;
    logic              dir_set;
    logic signed [1:0] dir_code;

    assign count_inc = count_reg + 8'd1;

    // Decode a direction byte
    always_comb begin
        dir_set  = 1'b1;
        dir_code = DIR_HOLD;
        case (rx_byte)
            CMD_BACK: dir_code = DIR_BACK;
            CMD_HOLD: dir_code = DIR_HOLD;
            CMD_FWD:  dir_code = DIR_FWD;
            default:  dir_set  = 1'b0;
        endcase
    end

    // Compute the next state for the item in hand
    always_comb begin
        phase_next = phase_reg;
        tgt_b_next = tgt_b_reg;
        dir_a_next = dir_a_reg;
        dir_b_next = dir_b_reg;
        width_next = width_reg;
        count_next = count_reg;
        pwm_next   = pwm_reg;
        step_fire  = 1'b0;
        unique case (req_type)
            REQ_BYTE: begin
                if (phase_reg == PH_IDLE) begin
                    if (rx_byte == CMD_START) begin
                        phase_next = PH_RECV;
                        tgt_b_next = 1'b0;
                    end
                end else if (phase_reg == PH_RECV) begin
                    if (rx_byte == CMD_PEN_UP) begin
                        tgt_b_next = 1'b1;
                        width_next = cfg.pen_up_width;
                    end else if (rx_byte == CMD_PEN_DOWN) begin
                        tgt_b_next = 1'b1;
                        width_next = cfg.pen_down_width;
                    end else if (rx_byte == CMD_END) begin
                        phase_next = PH_MOVING;
                    end else if (dir_set) begin
                        if (tgt_b_reg) dir_b_next = dir_code;
                        else           dir_a_next = dir_code;
                    end
                end
            end
            REQ_PWM: begin
                pwm_next   = (count_reg < width_reg);
                count_next = (count_inc >= cfg.pwm_period) ? 8'd0 : count_inc;
            end
            REQ_STEP: begin
                if (phase_reg == PH_MOVING) begin
                    step_fire  = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            REQ_ACK: begin
                if (phase_reg == PH_DONE) phase_next = PH_IDLE;
            end
            default: ;
        endcase
    end

    // Advance state when the item leaves the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tgt_b_reg <= 1'b0;
            dir_a_reg <= DIR_HOLD;
            dir_b_reg <= DIR_HOLD;
            width_reg <= PEN_UP_RESET;
            count_reg <= 8'd0;
            pwm_reg   <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            tgt_b_reg <= tgt_b_next;
            dir_a_reg <= dir_a_next;
            dir_b_reg <= dir_b_next;
            width_reg <= width_next;
            count_reg <= count_next;
            pwm_reg   <= pwm_next;
        end
    end

    assign res.step_valid = step_fire;
    assign res.step_a     = step_fire ? dir_a_reg : DIR_HOLD;
    assign res.step_b     = step_fire ? dir_b_reg : DIR_HOLD;
    assign res.pwm_level  = pwm_next;
    assign res.ctrl_phase = phase_next;

endmodule

// ----- sv/pen_step_command_controller.sv -----
// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+------------------------------------------
// s_        | in  | s_tvalid/s_tready  | tdata: rx_byte; tuser: req_type
// m_        | out | m_tvalid/m_tready  | tdata: step_a,step_b,pwm_level,ctrl_phase;
//           |     |                    | tuser: step_valid
// APB       | in  | psel/penable       | pen_up_width, pen_down_width, pwm_period
//
// An input word becomes a result word through one input register, then the state
// update and result register. One word per cycle is sustained while m_tready is
// high; the single shared state update sets this rate.
// Reset (aresetn low, synchronous) empties both stages and restores defaults.
// A stalled m_ side holds its word; s_tready drops only when both stages are full.
module pen_step_command_controller (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,  // [7:0] rx_byte
    input  logic [1:0]                   s_tuser,  // [1:0] req_type
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,  // [1:0] step_a, [3:2] step_b,
                                                   // [4] pwm_level, [6:5] ctrl_phase
    output logic                         m_tuser,  // [0] step_valid
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pscc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import pscc_pkg::*;

    cfg_t       cfg;
    res_t       res;
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic [1:0] in_req_reg;
    logic       out_vld_reg;
    res_t       out_res_reg;
    logic       out_free;
    logic       fire;

    assign out_free = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    // Input stage: load a new word whenever the stage empties
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_req_reg  <= s_tuser;
        end
    end

    // Output stage: hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= res;
        end
    end

    pscc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pscc_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .req_type (in_req_reg),
        .rx_byte  (in_byte_reg),
        .cfg      (cfg),
        .res      (res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_res_reg.ctrl_phase, out_res_reg.pwm_level,
                       out_res_reg.step_b, out_res_reg.step_a};
    assign m_tuser  = out_res_reg.step_valid;

endmodule

// ----- sv/pscc_checker.sv -----
module pscc_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tuser
);
    import pscc_pkg::*;

    // A fired move always leaves the controller waiting for acknowledge
    a_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[6:5] == PH_DONE))
        else $error("step fired without entering done");

    // Directions are zero unless a move fired
    a_step_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[3:0] == 4'd0))
        else $error("step directions set without a move");

    // A move needs the moving phase, so two moves never come back to back
    a_no_double: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser) |=> !(m_tvalid && m_tuser))
        else $error("second move fired without new frame");

    // Hold a stalled result word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result word changed while stalled");

endmodule

bind pen_step_command_controller pscc_checker u_pscc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
